### sv/crc_checked_command_frame_responder_assert.svh
// Assertion macros shared by the frame responder modules.
`ifndef CRC_CHECKED_COMMAND_FRAME_RESPONDER_ASSERT_SVH
`define CRC_CHECKED_COMMAND_FRAME_RESPONDER_ASSERT_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define CCFR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Whenever the antecedent holds, the consequent must hold in the next cycle.
`define CCFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

### sv/ccfr_pkg.sv
// Types, constants and CRC functions shared by the frame responder modules.
package ccfr_pkg;

    localparam int FRAME_BYTES_DEF = 12;
    localparam int QUEUE_DEPTH     = 2;
    localparam int REPLY_BYTES     = 12;
    localparam int REPLY_IDX_W     = $clog2(REPLY_BYTES);

    localparam logic [7:0]  START_MARK = 8'hDD;
    localparam logic [7:0]  CMD_REPLY  = 8'h31;
    localparam logic [7:0]  DIGIT_BASE = 8'h30;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;

    // Outcome of the three checks made on one completed frame.
    typedef struct packed {
        logic addr_ok;
        logic crc_ok;
        logic cmd_ok;
    } t_verdict;

    // One queue slot as it moves between modules.
    typedef struct packed {
        logic     valid;
        t_verdict verdict;
    } t_verdict_req;

    // One byte of CRC-16 CCITT, MSB first, no reflection.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // CRC over the nine fixed reply digits; evaluated at elaboration only.
    function automatic logic [15:0] reply_crc_calc();
        logic [15:0] c;
        c = CRC_INIT;
        for (int k = 1; k <= 9; k++) begin
            c = crc_byte(c, DIGIT_BASE + 8'(k));
        end
        return c;
    endfunction

    localparam logic [15:0] REPLY_CRC = reply_crc_calc();

    // Byte at a given position of the fixed reply frame.
    function automatic logic [7:0] reply_byte(input logic [REPLY_IDX_W-1:0] idx);
        logic [7:0] b;
        priority if (idx == REPLY_IDX_W'(0)) begin
            b = START_MARK;
        end else if (idx <= REPLY_IDX_W'(9)) begin
            b = DIGIT_BASE + 8'(idx);
        end else if (idx == REPLY_IDX_W'(10)) begin
            b = REPLY_CRC[7:0];
        end else if (idx == REPLY_IDX_W'(11)) begin
            b = REPLY_CRC[15:8];
        end else begin
            b = 8'h00;
        end
        return b;
    endfunction

endpackage

### sv/ccfr_front.sv
// Receive side: collects good bytes, runs the CRC and judges each completed frame.
`include "crc_checked_command_frame_responder_assert.svh"

module ccfr_front #(
    parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [7:0]             i_cfg_wdata,
    input  logic                   i_rx_valid,
    output logic                   o_rx_ready,
    input  logic [7:0]             i_rx_byte,
    input  logic                   i_rx_error,
    input  logic                   i_queue_full,
    output ccfr_pkg::t_verdict_req o_push
);

    localparam int CNT_W = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] LAST_IDX     = CNT_W'(FRAME_BYTES - 1);
    localparam logic [CNT_W-1:0] CRC_LO_IDX   = CNT_W'(FRAME_BYTES - 2);
    localparam logic [CNT_W-1:0] CRC_LAST_IDX = CNT_W'(FRAME_BYTES - 3);
    localparam logic [CNT_W-1:0] CMD_IDX      = CNT_W'(1);

    logic [7:0]       r_station;
    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_first_byte;
    logic             r_cmd_ok;
    logic [7:0]       r_crc_lo;
    logic             take;
    logic             frame_done;

    assign o_rx_ready = !i_queue_full;
    assign take       = i_rx_valid && o_rx_ready && !i_rx_error;
    assign frame_done = take && (r_count == LAST_IDX);

    always_comb begin
        n_count = r_count;
        n_crc   = r_crc;
        if (take) begin
            if (frame_done) begin
                n_count = '0;
                n_crc   = ccfr_pkg::CRC_INIT;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (r_count >= CMD_IDX && r_count <= CRC_LAST_IDX) begin
                    n_crc = ccfr_pkg::crc_byte(r_crc, i_rx_byte);
                end
            end
        end
    end

    always_comb begin
        o_push.valid           = frame_done;
        o_push.verdict.addr_ok = (r_first_byte == r_station) ||
                                 (r_first_byte == ccfr_pkg::START_MARK);
        o_push.verdict.crc_ok  = ({i_rx_byte, r_crc_lo} == r_crc);
        o_push.verdict.cmd_ok  = r_cmd_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station <= '0;
            r_count   <= '0;
            r_crc     <= ccfr_pkg::CRC_INIT;
        end else begin
            if (i_cfg_we) begin
                r_station <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_crc   <= n_crc;
        end
    end

    // Only the frame bytes that the checks look at are kept.
    always_ff @(posedge i_clk) begin
        if (take) begin
            if (r_count == '0) begin
                r_first_byte <= i_rx_byte;
            end
            if (r_count == CMD_IDX) begin
                r_cmd_ok <= (i_rx_byte == ccfr_pkg::CMD_REPLY);
            end
            if (r_count == CRC_LO_IDX) begin
                r_crc_lo <= i_rx_byte;
            end
        end
    end

    `CCFR_ASSERT_SAME(a_count_in_frame, i_clk, i_rst_n, 1'b1, r_count <= LAST_IDX)
    `CCFR_ASSERT_NEXT(a_crc_reloaded, i_clk, i_rst_n, frame_done, r_crc == ccfr_pkg::CRC_INIT)

endmodule

### sv/ccfr_queue.sv
// Short verdict queue that decouples the receive side from the reply side.
`include "crc_checked_command_frame_responder_assert.svh"

module ccfr_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ccfr_pkg::t_verdict_req i_push,
    output logic                   o_full,
    input  logic                   i_pop,
    output ccfr_pkg::t_verdict_req o_head
);

    localparam int DEPTH = ccfr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ccfr_pkg::t_verdict r_slot [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    assign o_head.valid   = (r_count != '0);
    assign o_head.verdict = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_push.verdict;
        end
    end

    `CCFR_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push.valid, !o_full)
    `CCFR_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, o_head.valid)

endmodule

### sv/ccfr_back.sv
// Reply side: plays out the fixed reply frame for each accepted verdict.
`include "crc_checked_command_frame_responder_assert.svh"

module ccfr_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  ccfr_pkg::t_verdict_req i_head,
    output logic                   o_pop,
    output logic                   o_tx_valid,
    input  logic                   i_tx_ready,
    output logic [7:0]             o_tx_byte,
    output logic                   o_tx_last
);

    localparam int IDX_W = ccfr_pkg::REPLY_IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ccfr_pkg::REPLY_BYTES - 1);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_valid, n_valid;
    logic [7:0]       r_data;
    logic             r_last;
    logic             out_free;
    logic             reply_ok;
    logic             load;

    assign out_free = !r_valid || i_tx_ready;
    assign reply_ok = i_head.verdict.addr_ok && i_head.verdict.crc_ok &&
                      i_head.verdict.cmd_ok;
    assign load     = i_head.valid && reply_ok && out_free;

    // A rejected verdict is dropped at once; an accepted one leaves the queue
    // with the last reply byte.
    assign o_pop = i_head.valid && (reply_ok ? (out_free && r_idx == LAST_IDX) : 1'b1);

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        if (load) begin
            n_idx   = (r_idx == LAST_IDX) ? '0 : r_idx + IDX_W'(1);
            n_valid = 1'b1;
        end else if (out_free) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= ccfr_pkg::reply_byte(r_idx);
            r_last <= (r_idx == LAST_IDX);
        end
    end

    assign o_tx_valid = r_valid;
    assign o_tx_byte  = r_data;
    assign o_tx_last  = r_last;

    `CCFR_ASSERT_SAME(a_last_wraps_index, i_clk, i_rst_n, r_valid && r_last, r_idx == '0)

endmodule

### sv/crc_checked_command_frame_responder.sv
// Top level of the CRC-checked command frame responder.
// Throughput: one request byte and one reply byte per cycle, both sides at once, while
// the queue has room and the sink keeps tready high. A verdict is registered in the queue, then
// the first reply byte goes into the output register; the next eleven follow one per cycle.
// A two-entry verdict queue holds judged frames behind a reply; tready drops when it is full.
// Reset (i_rst_n low, synchronous) empties the frame, the queue and the output register.
module crc_checked_command_frame_responder #(
    parameter int FRAME_BYTES = ccfr_pkg::FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Station address register.
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    // Received byte requests.
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_s_axis_tuser,   // [0] rx_error
    // Reply byte requests.
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] tx_byte
    output logic       o_m_axis_tlast    // tx_last
);

    ccfr_pkg::t_verdict_req push;
    ccfr_pkg::t_verdict_req head;
    logic                   queue_full;
    logic                   pop;

    // The receive side stores only the start byte, the command check and the
    // low CRC byte; the frame is judged on the cycle its last byte arrives and
    // the verdict of every completed frame goes into the queue.
    ccfr_front #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_s_axis_tvalid),
        .o_rx_ready  (o_s_axis_tready),
        .i_rx_byte   (i_s_axis_tdata),
        .i_rx_error  (i_s_axis_tuser),
        .i_queue_full(queue_full),
        .o_push      (push)
    );

    ccfr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_head (head)
    );

    // The reply side drops rejected verdicts at once and turns each
    // accepted one into the twelve-byte fixed reply.
    ccfr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .o_pop     (pop),
        .o_tx_valid(o_m_axis_tvalid),
        .i_tx_ready(i_m_axis_tready),
        .o_tx_byte (o_m_axis_tdata),
        .o_tx_last (o_m_axis_tlast)
    );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-checked command frame responder.
module tb_top;

    // Frame geometry and protocol constants, as the predictor sees them.
    localparam int          FRAME_LEN      = 12;
    localparam int          CRC_LAST       = FRAME_LEN - 3;
    localparam logic [7:0]  LEAD_BROADCAST = 8'hDD;
    localparam logic [7:0]  CMD_STATUS     = 8'h31;
    localparam logic [7:0]  DIGIT_ZERO     = 8'h30;
    localparam logic [15:0] CCITT_POLY     = 16'h1021;
    localparam logic [15:0] CCITT_SEED     = 16'hFFFF;

    // A verdict passes through the queue before its reply starts, so the settle time
    // covers a rejected frame whose verdict is still waiting in the queue.
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 105;
    localparam int ERR_PCT       = 6;
    localparam int MAX_REPORTS   = 50;

    typedef logic [7:0] t_frame [FRAME_LEN];

    // One received byte request as the sender presents it.
    typedef struct packed {
        logic [7:0] data;
        logic       err;
    } t_rx_req;

    // One reply byte as it should leave the block.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_reply_beat;

    typedef enum int {
        FR_GOOD,
        FR_BAD_LEAD,
        FR_BAD_CRC,
        FR_BAD_CMD,
        FR_NOISE,
        FR_TRUNCATED
    } t_frame_kind;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_cfg_we        = 1'b0;
    logic [7:0] i_cfg_wdata     = 8'h00;
    logic       i_s_axis_tvalid = 1'b0;
    logic       o_s_axis_tready;
    logic [7:0] i_s_axis_tdata  = 8'h00;   // [7:0] rx_byte
    logic       i_s_axis_tuser  = 1'b0;    // [0] rx_error
    logic       o_m_axis_tvalid;
    logic       i_m_axis_tready = 1'b0;
    logic [7:0] o_m_axis_tdata;            // [7:0] tx_byte
    logic       o_m_axis_tlast;            // tx_last

    // Requests waiting for the driver, and reply bytes the block still owes us.
    t_rx_req     pending_rx[$];
    t_reply_beat reply_q[$];

    // Predictor state: the register copy, the frame being collected and its CRC.
    logic [7:0]  station_addr = 8'h00;
    t_frame      rx_frame;
    int unsigned rx_fill      = 0;
    logic [15:0] crc_acc      = CCITT_SEED;

    int send_idle_pct = 33;
    int recv_idle_pct = 64;

    int unsigned errors         = 0;
    int unsigned cycles         = 0;
    int unsigned rx_taken       = 0;
    int unsigned rx_flagged     = 0;
    int unsigned beats_checked  = 0;
    int unsigned frames_replied = 0;
    int unsigned phase_queued   = 0;

    crc_checked_command_frame_responder #(
        .FRAME_BYTES(FRAME_LEN)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // CRC-16 CCITT, one message bit at a time, MSB first.
    function automatic logic [15:0] ccitt_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? CCITT_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Writes the trailer of a frame: CRC over the command and payload, low byte
    // first. A nonzero flip corrupts it on purpose.
    function automatic t_frame sealed(input t_frame f, input logic [15:0] flip);
        t_frame      g;
        logic [15:0] c;
        g = f;
        c = CCITT_SEED;
        for (int k = 1; k <= CRC_LAST; k++) begin
            c = ccitt_step(c, g[k]);
        end
        c = c ^ flip;
        g[FRAME_LEN-2] = c[7:0];
        g[FRAME_LEN-1] = c[15:8];
        return g;
    endfunction

    // Predicts the effect of one accepted byte request. Errored bytes leave the
    // state alone; the twelfth good byte closes the frame and judges it.
    function automatic void predict_rx(input logic [7:0] b, input logic err);
        logic [15:0] trailer;
        logic [15:0] sum;
        rx_taken++;
        if (err) begin
            rx_flagged++;
            return;
        end
        rx_frame[rx_fill] = b;
        if (rx_fill >= 1 && rx_fill <= CRC_LAST) begin
            crc_acc = ccitt_step(crc_acc, b);
        end
        rx_fill++;
        if (rx_fill < FRAME_LEN) begin
            return;
        end
        rx_fill = 0;
        sum     = crc_acc;
        crc_acc = CCITT_SEED;
        trailer = {rx_frame[FRAME_LEN-1], rx_frame[FRAME_LEN-2]};
        if ((rx_frame[0] != station_addr && rx_frame[0] != LEAD_BROADCAST) ||
            trailer != sum || rx_frame[1] != CMD_STATUS) begin
            return;
        end
        // Accepted: the reply is the broadcast lead, the digits 1 to 9 and their CRC.
        frames_replied++;
        reply_q.push_back('{data: LEAD_BROADCAST, last: 1'b0});
        sum = CCITT_SEED;
        for (int k = 1; k <= 9; k++) begin
            sum = ccitt_step(sum, DIGIT_ZERO + 8'(k));
            reply_q.push_back('{data: DIGIT_ZERO + 8'(k), last: 1'b0});
        end
        reply_q.push_back('{data: sum[7:0], last: 1'b0});
        reply_q.push_back('{data: sum[15:8], last: 1'b1});
    endfunction

    function automatic void push_rx(input logic [7:0] b, input logic err);
        pending_rx.push_back('{data: b, err: err});
        phase_queued++;
    endfunction

    // Queues a frame byte by byte, with line-error bytes sprinkled in between.
    function automatic void push_frame(input t_frame f);
        for (int k = 0; k < FRAME_LEN; k++) begin
            while ($urandom_range(99) < ERR_PCT) begin
                push_rx(8'($urandom_range(255)), 1'b1);
            end
            push_rx(f[k], 1'b0);
        end
    endfunction

    // Well-formed command frames with random payload half the time; the rest carry a
    // wrong lead byte, a wrong CRC, another command, pure noise, or a frame
    // that breaks off and is padded with noise so alignment is kept.
    function automatic void queue_random_frame();
        t_frame       f;
        t_frame_kind  kind;
        int unsigned  pick;
        int unsigned  cut;
        logic [15:0]  flip;
        pick = $urandom_range(99);
        kind = pick < 50 ? FR_GOOD : pick < 60 ? FR_BAD_LEAD : pick < 70 ? FR_BAD_CRC :
               pick < 80 ? FR_BAD_CMD : pick < 90 ? FR_NOISE : FR_TRUNCATED;
        for (int k = 0; k < FRAME_LEN; k++) begin
            f[k] = 8'($urandom_range(255));
        end
        f[0] = $urandom_range(1) ? station_addr : LEAD_BROADCAST;
        f[1] = CMD_STATUS;
        flip = 16'h0000;
        unique case (kind)
            FR_BAD_LEAD: begin
                do f[0] = 8'($urandom_range(255));
                while (f[0] == station_addr || f[0] == LEAD_BROADCAST);
            end
            FR_BAD_CMD: begin
                do f[1] = 8'($urandom_range(255));
                while (f[1] == CMD_STATUS);
            end
            FR_BAD_CRC: begin
                flip = 16'($urandom_range(1, 65535));
            end
            default: begin
            end
        endcase
        f = sealed(f, flip);
        if (kind == FR_NOISE) begin
            for (int k = 0; k < FRAME_LEN; k++) begin
                f[k] = 8'($urandom_range(255));
            end
        end else if (kind == FR_TRUNCATED) begin
            cut = $urandom_range(1, FRAME_LEN - 1);
            for (int k = cut; k < FRAME_LEN; k++) begin
                f[k] = 8'($urandom_range(255));
            end
        end
        push_frame(f);
    endfunction

    // The register is written at the edge where the enable is seen high; the
    // predictor takes the new value at that same edge.
    task automatic write_station_addr(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        station_addr = v;
    endtask

    // Waits until every request went in and every owed reply byte came out, then
    // lets the block finish judging a frame that may produce nothing.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_rx.size() != 0 || i_s_axis_tvalid || reply_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random_phase(input logic [7:0] addr, input int s_pct, input int r_pct);
        write_station_addr(addr);
        @(negedge i_clk);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        phase_queued  = 0;
        while (phase_queued < PHASE_ITEMS) begin
            queue_random_frame();
        end
        wait_drained();
    endtask

    // Sender: presents queued byte requests, holding each one until the block
    // takes it, and idles at random between them.
    always @(posedge i_clk) begin : rx_driver
        t_rx_req req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (pending_rx.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                req = pending_rx.pop_front();
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= req.data;
                i_s_axis_tuser  <= req.err;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stalls the reply side at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: checks each reply byte against the oldest one owed, then feeds the
    // byte request taken at this edge to the predictor. Doing both in one block
    // keeps the order fixed within the time step.
    always @(posedge i_clk) begin : reply_monitor
        t_reply_beat want;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (reply_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected reply byte: expected none, got %02h last %0b",
                                 $time, o_m_axis_tdata, o_m_axis_tlast);
                    end
                end else begin
                    want = reply_q.pop_front();
                    if (o_m_axis_tdata !== want.data) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: reply byte %0d tx_byte: expected %02h, got %02h",
                                     $time, beats_checked, want.data, o_m_axis_tdata);
                        end
                    end
                    if (o_m_axis_tlast !== want.last) begin
                        errors++;
                        if (errors <= MAX_REPORTS) begin
                            $display("%0t: reply byte %0d tx_last: expected %0b, got %0b",
                                     $time, beats_checked, want.last, o_m_axis_tlast);
                        end
                    end
                    beats_checked++;
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_rx(i_s_axis_tdata, i_s_axis_tuser);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: run did not drain within %0d cycles", $time, CYCLE_LIMIT);
            $display("[crc_checked_command_frame_responder] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_frame f;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, station address zero. First an accepted frame that is
        // addressed to the station itself, with payload bytes at both extremes
        // and two line-error bytes in the middle that must not disturb it.
        write_station_addr(8'h00);
        @(negedge i_clk);
        send_idle_pct = 33;
        recv_idle_pct = 64;
        f = '{8'h00, CMD_STATUS, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hFF, 8'h00,
              8'h00, 8'h00};
        f = sealed(f, 16'h0000);
        for (int k = 0; k < FRAME_LEN; k++) begin
            if (k == 5) begin
                push_rx(8'hFF, 1'b1);
                push_rx(8'h00, 1'b1);
            end
            push_rx(f[k], 1'b0);
        end
        // Then a broadcast frame whose trailer is off by one bit: no reply.
        f = '{LEAD_BROADCAST, CMD_STATUS, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
              8'hFF, 8'h00, 8'h00};
        f = sealed(f, 16'h0001);
        for (int k = 0; k < FRAME_LEN; k++) begin
            push_rx(f[k], 1'b0);
        end
        wait_drained();

        // Random part: address at its top value, then a random one, then equal
        // to the broadcast lead, with the idle pattern changing each time.
        run_random_phase(8'hFF, 33, 64);
        run_random_phase(8'($urandom_range(1, 254)), 64, 33);
        run_random_phase(LEAD_BROADCAST, 0, 0);

        $display("Sent %0d byte requests (%0d with a line error) over four address settings.",
                 rx_taken, rx_flagged);
        $display("Checked %0d reply bytes from %0d answered command frames.",
                 beats_checked, frames_replied);
        if (errors == 0) begin
            $display("[crc_checked_command_frame_responder] OK");
        end else begin
            $display("[crc_checked_command_frame_responder] ERROR");
        end
        $finish;
    end

endmodule
